/* rtl/thz_pkg.sv */
package thz_pkg;

  localparam int unsigned NumZones   = 3;
  localparam int unsigned TempW      = 12;
  localparam int unsigned SetpW      = 10;
  localparam int unsigned BandModeW  = 2;
  localparam int unsigned BandW      = 4;
  // signed working width: covers -18 .. 4095
  localparam int unsigned CmpW       = 13;
  localparam int unsigned AddrW      = 5;
  localparam int unsigned DataW      = 32;

  localparam logic [SetpW-1:0]     SetpReset  = SetpW'(165);
  localparam logic [BandModeW-1:0] BandReset  = '0;
  localparam logic [CmpW-1:0]      NightDrop  = CmpW'(10);
  localparam logic [BandW-1:0]     BandNormal = BandW'(5);
  localparam logic [BandW-1:0]     BandComfort = BandW'(3);
  localparam logic [BandW-1:0]     BandEco    = BandW'(8);

  typedef enum logic [2:0] {
    REG_SETP1 = 3'd0,
    REG_SETP2 = 3'd1,
    REG_SETP3 = 3'd2,
    REG_BAND  = 3'd3,
    REG_NIGHT = 3'd4
  } reg_idx_t;

  localparam logic [BandModeW-1:0] BAND_MODE_COMFORT = 2'd1;
  localparam logic [BandModeW-1:0] BAND_MODE_ECO     = 2'd2;

  typedef enum logic [1:0] {
    VALVE_NONE  = 2'd0,
    VALVE_OPEN  = 2'd1,
    VALVE_CLOSE = 2'd2
  } valve_t;

  typedef struct packed {
    logic [NumZones-1:0][SetpW-1:0] setpoint;
    logic [BandModeW-1:0]           band_mode;
    logic                           night_mode;
  } cfg_t;

  typedef struct packed {
    logic   heat;
    logic   alarm;
    valve_t event_code;
  } lane_res_t;

  typedef struct packed {
    logic [NumZones-1:0]  heat;
    logic                 boiler;
    logic [NumZones-1:0]  alarm;
    valve_t [NumZones-1:0] valve;
  } out_item_t;

  function automatic logic [BandW-1:0] half_band(input logic [BandModeW-1:0] mode);
    logic [BandW-1:0] b;
    case (mode)
      BAND_MODE_COMFORT: b = BandComfort;
      BAND_MODE_ECO:     b = BandEco;
      default:           b = BandNormal;
    endcase
    return b;
  endfunction

endpackage

/* rtl/three_zone_hysteresis_thermostat.sv */
// Three-zone hysteresis thermostat.
// Input channel (in_valid/in_ready): one item per evaluation tick, three zone
// temperatures in tenths of a degree and three window contacts.
// Output channel (out_valid/out_ready): one result item per input item, the
// zone heat flags, boiler drive, window alarms and valve open/close events.
// Config: APB-style port, registers at byte addresses 0,4,8 (setpoints),
// 12 (band mode), 16 (night mode); pready is always high. Write only while idle.
// Each result is registered in the output buffer's head entry or skid entry.
// Throughput: one item per cycle unless stalled; three zone lanes compare in
// parallel and a merge stage forms the boiler flag into a two-entry output
// buffer. When the receiver stalls, a second item is still taken into the skid
// entry; in_ready drops only when both entries are full.
// Reset (rst_n low, synchronous): all zone flags off, setpoints 165, band
// mode normal, night mode off, output buffer empty.
module three_zone_hysteresis_thermostat (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [thz_pkg::TempW-1:0]  in_temp_zone1,
  input  logic [thz_pkg::TempW-1:0]  in_temp_zone2,
  input  logic [thz_pkg::TempW-1:0]  in_temp_zone3,
  input  logic                       in_window_open1,
  input  logic                       in_window_open2,
  input  logic                       in_window_open3,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_heating_zone1,
  output logic                       out_heating_zone2,
  output logic                       out_heating_zone3,
  output logic                       out_boiler_on,
  output logic                       out_alarm_zone1,
  output logic                       out_alarm_zone2,
  output logic                       out_alarm_zone3,
  output logic [1:0]                 out_valve_event1,
  output logic [1:0]                 out_valve_event2,
  output logic [1:0]                 out_valve_event3,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [thz_pkg::AddrW-1:0]  paddr,
  input  logic [thz_pkg::DataW-1:0]  pwdata,
  output logic [thz_pkg::DataW-1:0]  prdata,
  output logic                       pready
);

  thz_pkg::cfg_t                              cfg;
  thz_pkg::lane_res_t [thz_pkg::NumZones-1:0] lanes;
  thz_pkg::out_item_t                         item;
  logic [thz_pkg::NumZones-1:0][thz_pkg::TempW-1:0] temps;
  logic [thz_pkg::NumZones-1:0]               windows;
  logic [thz_pkg::BandW-1:0]                  band;
  logic                                       accept;

  assign temps   = {in_temp_zone3, in_temp_zone2, in_temp_zone1};
  assign windows = {in_window_open3, in_window_open2, in_window_open1};
  assign band    = thz_pkg::half_band(cfg.band_mode);
  assign accept  = in_valid & in_ready;

  thz_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  for (genvar z = 0; z < thz_pkg::NumZones; z++) begin : g_lane
    thz_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .accept   (accept),
      .temp     (temps[z]),
      .window   (windows[z]),
      .setpoint (cfg.setpoint[z]),
      .band     (band),
      .night    (cfg.night_mode),
      .res      (lanes[z])
    );
  end

  thz_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .lanes     (lanes),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .item      (item)
  );

  assign out_heating_zone1 = item.heat[0];
  assign out_heating_zone2 = item.heat[1];
  assign out_heating_zone3 = item.heat[2];
  assign out_boiler_on     = item.boiler;
  assign out_alarm_zone1   = item.alarm[0];
  assign out_alarm_zone2   = item.alarm[1];
  assign out_alarm_zone3   = item.alarm[2];
  assign out_valve_event1  = item.valve[0];
  assign out_valve_event2  = item.valve[1];
  assign out_valve_event3  = item.valve[2];

endmodule

/* rtl/thz_cfg.sv */
module thz_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [thz_pkg::AddrW-1:0]  paddr,
  input  logic [thz_pkg::DataW-1:0]  pwdata,
  output logic [thz_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output thz_pkg::cfg_t              cfg
);

  thz_pkg::cfg_t    cfg_r;
  thz_pkg::cfg_t    cfg_nxt;
  logic             wr_en;
  thz_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = thz_pkg::reg_idx_t'(paddr[thz_pkg::AddrW-1:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        thz_pkg::REG_SETP1: cfg_nxt.setpoint[0] = pwdata[thz_pkg::SetpW-1:0];
        thz_pkg::REG_SETP2: cfg_nxt.setpoint[1] = pwdata[thz_pkg::SetpW-1:0];
        thz_pkg::REG_SETP3: cfg_nxt.setpoint[2] = pwdata[thz_pkg::SetpW-1:0];
        thz_pkg::REG_BAND:  cfg_nxt.band_mode   = pwdata[thz_pkg::BandModeW-1:0];
        thz_pkg::REG_NIGHT: cfg_nxt.night_mode  = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      thz_pkg::REG_SETP1: prdata = thz_pkg::DataW'(cfg_r.setpoint[0]);
      thz_pkg::REG_SETP2: prdata = thz_pkg::DataW'(cfg_r.setpoint[1]);
      thz_pkg::REG_SETP3: prdata = thz_pkg::DataW'(cfg_r.setpoint[2]);
      thz_pkg::REG_BAND:  prdata = thz_pkg::DataW'(cfg_r.band_mode);
      thz_pkg::REG_NIGHT: prdata = thz_pkg::DataW'(cfg_r.night_mode);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint   <= {thz_pkg::NumZones{thz_pkg::SetpReset}};
      cfg_r.band_mode  <= thz_pkg::BandReset;
      cfg_r.night_mode <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/thz_lane.sv */
module thz_lane (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [thz_pkg::TempW-1:0]   temp,
  input  logic                        window,
  input  logic [thz_pkg::SetpW-1:0]   setpoint,
  input  logic [thz_pkg::BandW-1:0]   band,
  input  logic                        night,
  output thz_pkg::lane_res_t          res
);

  logic                            heat_r;
  logic                            heat_nxt;
  logic signed [thz_pkg::CmpW-1:0] t_s;
  logic signed [thz_pkg::CmpW-1:0] sp_s;
  logic signed [thz_pkg::CmpW-1:0] on_lvl;
  logic signed [thz_pkg::CmpW-1:0] off_lvl;
  logic                            turn_on;
  logic                            turn_off;

  always_comb begin
    t_s     = $signed(thz_pkg::CmpW'(temp));
    sp_s    = $signed(thz_pkg::CmpW'(setpoint) - (night ? thz_pkg::NightDrop : '0));
    on_lvl  = sp_s - $signed(thz_pkg::CmpW'(band));
    off_lvl = sp_s + $signed(thz_pkg::CmpW'(band));
    turn_on  = !heat_r && (t_s <= on_lvl);
    turn_off = heat_r && (t_s >= off_lvl);
    heat_nxt = turn_on | (heat_r & ~turn_off);

    res.heat  = heat_nxt;
    res.alarm = window & heat_nxt;
    if (turn_on)       res.event_code = thz_pkg::VALVE_OPEN;
    else if (turn_off) res.event_code = thz_pkg::VALVE_CLOSE;
    else               res.event_code = thz_pkg::VALVE_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heat_r <= 1'b0;
    end else if (accept) begin
      heat_r <= heat_nxt;
    end
  end

endmodule

/* rtl/thz_merge.sv */
module thz_merge (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  thz_pkg::lane_res_t [thz_pkg::NumZones-1:0] lanes,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output thz_pkg::out_item_t                     item
);

  thz_pkg::out_item_t merged;
  thz_pkg::out_item_t head_r, head_nxt;
  thz_pkg::out_item_t skid_r, skid_nxt;
  logic               head_v_r, head_v_nxt;
  logic               skid_v_r, skid_v_nxt;
  logic               push, pop;

  always_comb begin
    for (int z = 0; z < thz_pkg::NumZones; z++) begin
      merged.heat[z]  = lanes[z].heat;
      merged.alarm[z] = lanes[z].alarm;
      merged.valve[z] = lanes[z].event_code;
    end
    merged.boiler = |merged.heat;
  end

  assign in_ready  = !skid_v_r;
  assign push      = in_valid & in_ready;
  assign pop       = head_v_r & out_ready;
  assign out_valid = head_v_r;
  assign item      = head_r;

  always_comb begin
    head_nxt   = head_r;
    skid_nxt   = skid_r;
    head_v_nxt = head_v_r;
    skid_v_nxt = skid_v_r;
    if (skid_v_r) begin
      if (pop) begin
        head_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!head_v_r || pop) begin
        head_nxt   = merged;
        head_v_nxt = 1'b1;
      end else begin
        skid_nxt   = merged;
        skid_v_nxt = 1'b1;
      end
    end else if (pop) begin
      head_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  // skid only fills behind an occupied head
  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> head_v_r)
    else $error("skid entry without head entry");

  a_boiler_or: assert property (@(posedge clk) disable iff (!rst_n)
    head_v_r |-> (head_r.boiler == (|head_r.heat)))
    else $error("boiler does not match zone flags");

  a_alarm_heat: assert property (@(posedge clk) disable iff (!rst_n)
    head_v_r |-> ((head_r.alarm & ~head_r.heat) == '0))
    else $error("alarm raised on a zone that is not heating");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (head_v_r && !out_ready) |=> (head_v_r && $stable(head_r)))
    else $error("stalled result changed");

endmodule
